// ===== rtl/core/pdfa_pkg.sv =====
// Package for the programmable DFA recognizer: sizes, opcode and verdict codes,
// and configuration register indexes.
// No dependencies.
package pdfa_pkg;

	// Machine size
	localparam int unsigned STATE_COUNT  = 64;
	localparam int unsigned SYMBOL_COUNT = 16;
	localparam int unsigned STATE_W      = $clog2(STATE_COUNT);
	localparam int unsigned SLOT_W       = $clog2(SYMBOL_COUNT);
	localparam int unsigned TABLE_DEPTH  = STATE_COUNT * SYMBOL_COUNT;
	localparam int unsigned ADDR_W       = $clog2(TABLE_DEPTH);

	// Field widths fixed by the interface
	localparam int unsigned OPCODE_W      = 2;
	localparam int unsigned SLOT_FIELD_W  = 4;
	localparam int unsigned STATE_FIELD_W = 6;
	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned VERDICT_W     = 2;
	localparam int unsigned COUNT_W       = 5;
	localparam int unsigned ACCEPT_W      = 64;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 64;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_SYMBOL = 2'd0,
		OP_LOAD_TRANS  = 2'd1,
		OP_FEED_CHAR   = 2'd2
	} opcode_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPTED = 2'd0,
		VERDICT_REJECTED = 2'd1,
		VERDICT_INVALID  = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_STATE  = 2'd0,
		REG_SYMBOL_COUNT = 2'd1,
		REG_ACCEPT_MAP   = 2'd2
	} cfg_reg_t;

endpackage

// ===== rtl/core/pdfa_in_if.sv =====
// Input channel of the DFA recognizer: valid/ready plus load or character fields.
// Depends on pdfa_pkg.
interface pdfa_in_if;
	logic                                valid;
	logic                                ready;
	logic [pdfa_pkg::OPCODE_W-1:0]      opcode;
	logic [pdfa_pkg::SLOT_FIELD_W-1:0]  slot;
	logic [pdfa_pkg::STATE_FIELD_W-1:0] from_state;
	logic [pdfa_pkg::STATE_FIELD_W-1:0] target_state;
	logic [pdfa_pkg::CHAR_W-1:0]        char_value;
	logic                                last_char;

	modport source (output valid, opcode, slot, from_state, target_state, char_value,
		last_char, input ready);
	modport sink (input valid, opcode, slot, from_state, target_state, char_value,
		last_char, output ready);
endinterface

// ===== rtl/core/pdfa_out_if.sv =====
// Result channel of the DFA recognizer: valid/ready plus verdict fields.
// Depends on pdfa_pkg.
interface pdfa_out_if;
	logic                                valid;
	logic                                ready;
	logic [pdfa_pkg::VERDICT_W-1:0]     verdict;
	logic [pdfa_pkg::STATE_FIELD_W-1:0] final_state;
	logic [pdfa_pkg::CHAR_W-1:0]        bad_char;

	modport source (output valid, verdict, final_state, bad_char, input ready);
	modport sink (input valid, verdict, final_state, bad_char, output ready);
endinterface

// ===== rtl/core/programmable_dfa_recognizer.sv =====
// A result is registered in stage one, then in the output register.
// Throughput: one item per cycle unless a finished result stalls in stage one;
// the registered next-state read data of the transition memory forms the next read address.
// Reset: control state and configuration registers clear; symbol slots and the transition
// memory are undefined until loaded, no clearing pass.
// Depends on pdfa_pkg, pdfa_in_if, pdfa_out_if.
module programmable_dfa_recognizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdfa_pkg::CFG_DATA_W-1:0] cfg_data,
	pdfa_in_if.sink                         in_ch,
	pdfa_out_if.source                      out_ch
);

	typedef struct packed {
		logic                              from_rd;
		logic [pdfa_pkg::STATE_W-1:0]      state;
		logic                              invalid;
		logic [pdfa_pkg::CHAR_W-1:0]       bad;
	} s1_t;

	// Configuration registers
	logic [pdfa_pkg::STATE_FIELD_W-1:0] start_state_q;
	logic [pdfa_pkg::COUNT_W-1:0]       symbol_count_q;
	logic [pdfa_pkg::ACCEPT_W-1:0]      accept_map_q;

	// Stores
	logic [pdfa_pkg::CHAR_W-1:0]  symbol_q [pdfa_pkg::SYMBOL_COUNT];
	logic [pdfa_pkg::STATE_W-1:0] trans_mem [pdfa_pkg::TABLE_DEPTH];
	logic [pdfa_pkg::STATE_W-1:0] rd_q;

	// Run state
	logic                          mid_q;
	logic                          invalid_q;
	logic [pdfa_pkg::CHAR_W-1:0]   bad_q;
	logic [pdfa_pkg::STATE_W-1:0]  state_q;
	logic                          use_rd_q;

	// Result stage and output register
	logic                          valid_s1;
	s1_t                           res_s1;
	logic                          out_valid_q;
	logic [pdfa_pkg::VERDICT_W-1:0]     verdict_q;
	logic [pdfa_pkg::STATE_FIELD_W-1:0] final_q;
	logic [pdfa_pkg::CHAR_W-1:0]        bad_out_q;

	logic                          accept;
	logic                          is_char;
	logic                          is_sym;
	logic                          is_trans;
	logic                          s1_move;
	logic [pdfa_pkg::STATE_W-1:0]  cur_state;
	logic [pdfa_pkg::STATE_W-1:0]  run_st;
	logic                          run_inv;
	logic [pdfa_pkg::CHAR_W-1:0]   run_bad;
	logic                          hit;
	logic [pdfa_pkg::SLOT_W-1:0]   hit_slot;
	logic                          do_read;
	logic                          next_inv;
	logic [pdfa_pkg::CHAR_W-1:0]   next_bad;
	logic [pdfa_pkg::ADDR_W-1:0]   rd_addr;
	logic [pdfa_pkg::ADDR_W-1:0]   wr_addr;
	logic [pdfa_pkg::STATE_W-1:0]  fin_state;

	// Handshake: stall only when a finished result cannot leave stage one
	assign s1_move      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !(valid_s1 && !s1_move);
	assign accept       = in_ch.valid && in_ch.ready;
	assign is_char      = accept && (in_ch.opcode == pdfa_pkg::OP_FEED_CHAR);
	assign is_sym       = accept && (in_ch.opcode == pdfa_pkg::OP_LOAD_SYMBOL);
	assign is_trans     = accept && (in_ch.opcode == pdfa_pkg::OP_LOAD_TRANS);

	// Current state comes from the memory read data when the last character moved
	assign cur_state = use_rd_q ? rd_q : state_q;

	// Start a fresh string on its first character
	always_comb begin
		if (!mid_q) begin
			run_st  = start_state_q[pdfa_pkg::STATE_W-1:0];
			run_inv = 1'b0;
			run_bad = '0;
		end else begin
			run_st  = cur_state;
			run_inv = invalid_q;
			run_bad = bad_q;
		end
	end

	// Match the character against the active slots, lowest slot wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int j = pdfa_pkg::SYMBOL_COUNT - 1; j >= 0; j--) begin
			if ((symbol_q[j] == in_ch.char_value) &&
				(pdfa_pkg::COUNT_W'(j) < symbol_count_q)) begin
				hit      = 1'b1;
				hit_slot = pdfa_pkg::SLOT_W'(j);
			end
		end
	end

	assign do_read  = is_char && !run_inv && hit;
	assign next_inv = run_inv || !hit;
	assign next_bad = (!run_inv && !hit) ? in_ch.char_value : run_bad;
	assign rd_addr  = {run_st, hit_slot};
	assign wr_addr  = {in_ch.from_state[pdfa_pkg::STATE_W-1:0],
		in_ch.slot[pdfa_pkg::SLOT_W-1:0]};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q  <= '0;
			symbol_count_q <= '0;
			accept_map_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdfa_pkg::REG_START_STATE:
					start_state_q <= cfg_data[pdfa_pkg::STATE_FIELD_W-1:0];
				pdfa_pkg::REG_SYMBOL_COUNT:
					symbol_count_q <= cfg_data[pdfa_pkg::COUNT_W-1:0];
				pdfa_pkg::REG_ACCEPT_MAP:
					accept_map_q <= cfg_data[pdfa_pkg::ACCEPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Symbol slots
	always_ff @(posedge clk) begin
		if (is_sym) begin
			symbol_q[in_ch.slot[pdfa_pkg::SLOT_W-1:0]] <= in_ch.char_value;
		end
	end

	// Transition memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (is_trans) begin
			trans_mem[wr_addr] <= in_ch.target_state[pdfa_pkg::STATE_W-1:0];
		end
		if (do_read) begin
			rd_q <= trans_mem[rd_addr];
		end
	end

	// Advance the run state on each character transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q     <= 1'b0;
			invalid_q <= 1'b0;
			bad_q     <= '0;
			state_q   <= '0;
			use_rd_q  <= 1'b0;
		end else if (is_char) begin
			mid_q     <= !in_ch.last_char;
			invalid_q <= next_inv;
			bad_q     <= next_bad;
			state_q   <= run_st;
			use_rd_q  <= do_read;
		end
	end

	// Stage one: hold the end-of-string snapshot until the read data is back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (is_char && in_ch.last_char) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_char && in_ch.last_char) begin
			res_s1.from_rd <= do_read;
			res_s1.state   <= run_st;
			res_s1.invalid <= next_inv;
			res_s1.bad     <= next_bad;
		end
	end

	assign fin_state = res_s1.from_rd ? rd_q : res_s1.state;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			final_q <= pdfa_pkg::STATE_FIELD_W'(fin_state);
			if (res_s1.invalid) begin
				verdict_q <= pdfa_pkg::VERDICT_INVALID;
				bad_out_q <= res_s1.bad;
			end else begin
				verdict_q <= accept_map_q[fin_state] ? pdfa_pkg::VERDICT_ACCEPTED
					: pdfa_pkg::VERDICT_REJECTED;
				bad_out_q <= '0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.verdict     = verdict_q;
	assign out_ch.final_state = final_q;
	assign out_ch.bad_char    = bad_out_q;

endmodule
